>>> hw/rtl/blul_pkg.sv
`default_nettype none

package blul_pkg;

    // link characters
    localparam logic [7:0] CH_W = 8'h57;
    localparam logic [7:0] CH_R = 8'h52;
    localparam logic [7:0] CH_B = 8'h42;
    localparam logic [7:0] CH_U = 8'h55;
    localparam logic [7:0] CH_X = 8'h58;

    // two-byte replies
    localparam logic [15:0] REPLY_OK = 16'h4F4B;
    localparam logic [15:0] REPLY_BC = 16'h4243;
    localparam logic [15:0] REPLY_BX = 16'h4258;

    // session status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD_SUM = 2'd1;
    localparam logic [1:0] STATUS_BAD_CMD = 2'd2;

    // session phase, unused codes behave as idle
    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_WAITB  = 4'd1,
        PH_CMD    = 4'd2,
        PH_ADDR   = 4'd3,
        PH_LEN    = 4'd4,
        PH_DATA   = 4'd5,
        PH_CSUM   = 4'd6,
        PH_REPLY  = 4'd7,
        PH_REPLY2 = 4'd8
    } t_phase;

    // one reply item
    typedef struct packed {
        logic [7:0]  tx_byte;
        logic        mem_write;
        logic [31:0] write_address;
        logic [7:0]  write_data;
        logic        exec_request;
        logic [31:0] exec_vector_address;
        logic        session_end;
        logic [1:0]  session_status;
    } t_result;

endpackage

`default_nettype wire

>>> hw/rtl/blul_step.sv
`default_nettype none

module blul_step (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_take,
    input  wire logic [7:0]        i_rx_byte,
    output blul_pkg::t_result      o_res,
    output logic                   o_res_valid
);
    import blul_pkg::*;

    t_phase      r_phase, n_phase;
    logic        r_execute_flag, n_execute_flag;
    logic [1:0]  r_byte_counter, n_byte_counter;
    logic [31:0] r_load_address, n_load_address;
    logic [31:0] r_bytes_remaining, n_bytes_remaining;
    logic [31:0] r_write_pointer, n_write_pointer;
    logic [15:0] r_running_sum, n_running_sum;
    logic [15:0] r_received_sum, n_received_sum;
    logic [15:0] r_reply_word, n_reply_word;

    logic [31:0] length_next;
    logic [31:0] remaining_dec;
    logic [15:0] sum_next;

    assign length_next   = {r_bytes_remaining[23:0], i_rx_byte};
    assign remaining_dec = r_bytes_remaining - 32'd1;
    assign sum_next      = {r_received_sum[7:0], i_rx_byte};

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase           <= PH_IDLE;
            r_execute_flag    <= 1'b0;
            r_byte_counter    <= 2'd0;
            r_load_address    <= 32'd0;
            r_bytes_remaining <= 32'd0;
            r_write_pointer   <= 32'd0;
            r_running_sum     <= 16'd0;
            r_received_sum    <= 16'd0;
            r_reply_word      <= 16'd0;
        end else if (i_take) begin
            r_phase           <= n_phase;
            r_execute_flag    <= n_execute_flag;
            r_byte_counter    <= n_byte_counter;
            r_load_address    <= n_load_address;
            r_bytes_remaining <= n_bytes_remaining;
            r_write_pointer   <= n_write_pointer;
            r_running_sum     <= n_running_sum;
            r_received_sum    <= n_received_sum;
            r_reply_word      <= n_reply_word;
        end
    end

    // next state and reply for one received byte
    always_comb begin
        n_phase           = r_phase;
        n_execute_flag    = r_execute_flag;
        n_byte_counter    = r_byte_counter;
        n_load_address    = r_load_address;
        n_bytes_remaining = r_bytes_remaining;
        n_write_pointer   = r_write_pointer;
        n_running_sum     = r_running_sum;
        n_received_sum    = r_received_sum;
        n_reply_word      = r_reply_word;
        o_res             = '0;
        o_res.tx_byte     = i_rx_byte;
        o_res_valid       = 1'b1;

        unique case (r_phase)
            PH_WAITB: begin
                o_res.tx_byte = CH_W;
                if (i_rx_byte == CH_B) begin
                    n_phase = PH_CMD;
                end
            end
            PH_CMD: begin
                n_running_sum  = 16'd0;
                n_byte_counter = 2'd0;
                n_execute_flag = (i_rx_byte == CH_X);
                if (i_rx_byte == CH_U || i_rx_byte == CH_X) begin
                    n_phase = PH_ADDR;
                end else begin
                    n_reply_word = REPLY_BX;
                    n_phase      = PH_REPLY;
                end
            end
            PH_ADDR: begin
                n_load_address = {r_load_address[23:0], i_rx_byte};
                if (r_byte_counter == 2'd3) begin
                    n_byte_counter = 2'd0;
                    n_phase        = PH_LEN;
                end else begin
                    n_byte_counter = r_byte_counter + 2'd1;
                end
            end
            PH_LEN: begin
                n_bytes_remaining = length_next;
                if (r_byte_counter == 2'd3) begin
                    n_byte_counter  = 2'd0;
                    n_write_pointer = r_load_address;
                    n_phase         = (length_next == 32'd0) ? PH_CSUM : PH_DATA;
                end else begin
                    n_byte_counter = r_byte_counter + 2'd1;
                end
            end
            PH_DATA: begin
                o_res.mem_write     = 1'b1;
                o_res.write_address = r_write_pointer;
                o_res.write_data    = i_rx_byte;
                n_write_pointer     = r_write_pointer + 32'd1;
                n_running_sum       = r_running_sum + {8'd0, i_rx_byte};
                n_bytes_remaining   = remaining_dec;
                if (remaining_dec == 32'd0) begin
                    n_byte_counter = 2'd0;
                    n_phase        = PH_CSUM;
                end
            end
            PH_CSUM: begin
                n_received_sum = sum_next;
                if (r_byte_counter == 2'd1) begin
                    n_byte_counter = 2'd0;
                    n_reply_word   = (sum_next == r_running_sum) ? REPLY_OK : REPLY_BC;
                    n_phase        = PH_REPLY;
                end else begin
                    n_byte_counter = 2'd1;
                end
            end
            PH_REPLY, PH_REPLY2: begin
                if (r_byte_counter == 2'd0) begin
                    o_res.tx_byte  = r_reply_word[15:8];
                    n_byte_counter = 2'd1;
                end else begin
                    o_res.tx_byte  = r_reply_word[7:0];
                    n_byte_counter = 2'd0;
                    if (r_phase == PH_REPLY && r_reply_word == REPLY_OK && r_execute_flag) begin
                        o_res.exec_request        = 1'b1;
                        o_res.exec_vector_address = r_load_address;
                        n_phase                   = PH_REPLY2;
                    end else begin
                        o_res.session_end = 1'b1;
                        if (r_reply_word == REPLY_OK) begin
                            o_res.session_status = STATUS_OK;
                        end else if (r_reply_word == REPLY_BC) begin
                            o_res.session_status = STATUS_BAD_SUM;
                        end else begin
                            o_res.session_status = STATUS_BAD_CMD;
                        end
                        n_phase = PH_IDLE;
                    end
                end
            end
            default: begin
                // idle: only a 'W' opens a session
                n_phase = PH_IDLE;
                if (i_rx_byte == CH_W) begin
                    o_res.tx_byte = CH_R;
                    n_phase       = PH_WAITB;
                end else begin
                    o_res_valid = 1'b0;
                end
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    // execute request leads to the second reply
    a_exec_to_reply2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && o_res.exec_request |=> r_phase == PH_REPLY2)
        else $error("exec request did not enter second reply");

    // session end returns to idle with a clean counter
    a_end_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && o_res.session_end |=> r_phase == PH_IDLE && r_byte_counter == 2'd0)
        else $error("session end did not return to idle");

    // a payload write always has bytes left to count
    a_write_has_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && o_res.mem_write |-> r_bytes_remaining != 32'd0)
        else $error("payload write with zero bytes remaining");

    // write pointer steps by one per payload byte
    a_pointer_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && r_phase == PH_DATA |=> r_write_pointer == $past(r_write_pointer) + 32'd1)
        else $error("write pointer did not advance");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/blul_out_queue.sv
`default_nettype none

module blul_out_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire blul_pkg::t_result i_data,
    output logic                   o_full,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output blul_pkg::t_result      o_data
);
    import blul_pkg::*;

    t_result    r_slot [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       pop;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_data  = r_slot[r_rd_ptr];
    assign pop     = o_valid && !i_stall;

    // pointer and count update
    always_comb begin
        n_wr_ptr = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // result storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

`ifndef NO_ASSERTIONS
    // never push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full result queue");

    // count stays within the two slots
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("result queue count out of range");

    // pointers differ exactly when one slot is held
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr != r_rd_ptr) == (r_count == 2'd1))
        else $error("queue pointers disagree with count");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/byte_link_upload_loader_core.sv
// Byte-link upload loader. Each received link byte on the rx channel yields
// at most one reply byte on the tx channel, together with a memory write
// strobe, address and data for payload bytes, an execute request with the
// vector address, and an end-of-session flag with status. A byte is taken
// every cycle while rx is not stalled; the combinational next-state logic
// between the rx input register and a two-entry result queue sets that rate.
// A reply passes from the input register through the result queue to tx,
// where a tx stall can hold it. Idle bytes other than 'W' give no reply. rx
// stalls only while the input register holds a byte and the result queue is
// full.
`default_nettype none

module byte_link_upload_loader_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_rx_valid,
    output logic             o_rx_stall,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_tx_valid,
    input  wire logic        i_tx_stall,
    output logic [7:0]       o_tx_byte,
    output logic             o_mem_write,
    output logic [31:0]      o_write_address,
    output logic [7:0]       o_write_data,
    output logic             o_exec_request,
    output logic [31:0]      o_exec_vector_address,
    output logic             o_session_end,
    output logic [1:0]       o_session_status
);
    import blul_pkg::*;

    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte;
    logic       accept;
    logic       take;
    logic       q_full;
    t_result    step_res;
    logic       step_res_valid;
    t_result    q_data;

    assign accept     = i_rx_valid && !o_rx_stall;
    assign take       = r_in_valid && !q_full;
    assign o_rx_stall = r_in_valid && q_full;

    // input register
    always_comb begin
        n_in_valid = r_in_valid;
        if (accept) begin
            n_in_valid = 1'b1;
        end else if (take) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // session sequencer
    blul_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_rx_byte   (r_in_byte),
        .o_res       (step_res),
        .o_res_valid (step_res_valid)
    );

    // reply queue
    blul_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take && step_res_valid),
        .i_data  (step_res),
        .o_full  (q_full),
        .o_valid (o_tx_valid),
        .i_stall (i_tx_stall),
        .o_data  (q_data)
    );

    assign o_tx_byte             = q_data.tx_byte;
    assign o_mem_write           = q_data.mem_write;
    assign o_write_address       = q_data.write_address;
    assign o_write_data          = q_data.write_data;
    assign o_exec_request        = q_data.exec_request;
    assign o_exec_vector_address = q_data.exec_vector_address;
    assign o_session_end         = q_data.session_end;
    assign o_session_status      = q_data.session_status;

endmodule

`default_nettype wire
